// ===== hdl/sld_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sld_pkg
// constants, register codes and helper tables for the shrinkage ld kernel
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int INDEX_BITS_DEF = 10;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [19:0] POP_SIZE_RST  = 20'd10000;
    localparam logic [15:0] HAP_COUNT_RST = 16'd100;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [37:0] LN2_Q32 = 38'd2977044472;

    localparam int TERMS     = 14;
    localparam int DIV_BITS  = 21;
    localparam int DIV_STEPS = 3;
    localparam int LN_BITS   = 6;
    localparam int LN_STEPS  = 3;
    localparam int SQ_BITS   = 32;
    localparam int SQ_STEPS  = 2;
    localparam int FD_BITS   = 31;
    localparam int FD_STEPS  = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_POP_SIZE  = 3'd0,
        REG_HAP_COUNT = 3'd1,
        REG_THETA     = 3'd2,
        REG_CUTOFF    = 3'd3,
        REG_DIAG      = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic        forced;
        logic        forced_one;
        logic        neg;
        logic [31:0] mag;
        logic [30:0] va;
        logic [30:0] vb;
    } item_t;

    // floor(2^36 / k) for the taylor term divisors
    function automatic logic [36:0] recip(input int k);
        logic [36:0] r;
        case (k)
            1:       r = 37'd68719476736;
            2:       r = 37'd34359738368;
            3:       r = 37'd22906492245;
            4:       r = 37'd17179869184;
            5:       r = 37'd13743895347;
            6:       r = 37'd11453246122;
            7:       r = 37'd9817068105;
            8:       r = 37'd8589934592;
            9:       r = 37'd7635497415;
            10:      r = 37'd6871947673;
            11:      r = 37'd6247225157;
            12:      r = 37'd5726623061;
            13:      r = 37'd5286113595;
            14:      r = 37'd4908534052;
            default: r = 37'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/shrinkage_ld_correlation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shrinkage_ld_correlation
// pipelined shrinkage ld kernel: distance decay weight, shrunk variances,
// square root and saturating divide, one matrix element per word
// ----------------------------------------------------------------------------
// channel   direction  handshake                  payload
// item      in         item_valid/item_stall      row_index col_index pos_a pos_b
//                                                 cov_ab var_a var_b
// result    out        result_valid/result_stall  ld_corr
// cfg       in         cfg_valid/cfg_ready        cfg_index cfg_data
//
// one word enters per cycle while the result side is not stalling; 91 register
// stages lie between an accepted word and its result
// pipeline depth is set by the taylor series (three stages per term), the rate divider
// (three bits per stage) and the root and final divide (two bits per stage)
// reset clears the valid bits and loads the register defaults
// a stalled result freezes the whole pipeline, item_stall follows it
// ----------------------------------------------------------------------------
module shrinkage_ld_correlation #(
    parameter int INDEX_BITS = sld_pkg::INDEX_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [INDEX_BITS-1:0]          row_index,
    input  wire logic [INDEX_BITS-1:0]          col_index,
    input  wire logic [31:0]                    pos_a,
    input  wire logic [31:0]                    pos_b,
    input  wire logic signed [31:0]             cov_ab,
    input  wire logic [30:0]                    var_a,
    input  wire logic [30:0]                    var_b,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic signed [31:0]                  ld_corr,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sld_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sld_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sld_pkg::*;

    localparam int DIV_ST = DIV_BITS / DIV_STEPS;
    localparam int LN_ST  = LN_BITS / LN_STEPS;
    localparam int TAY_ST = 3 * TERMS;
    localparam int SQ_ST  = (SQ_BITS + SQ_STEPS - 1) / SQ_STEPS;
    localparam int FD_ST  = (FD_BITS + FD_STEPS - 1) / FD_STEPS;
    localparam int NST    = 3 + DIV_ST + LN_ST + TAY_ST + 3 + SQ_ST + 1 + FD_ST + 1;

    typedef struct packed {
        logic        ovf;
        logic [21:0] rem;
        logic [20:0] low;
    } div_t;

    typedef struct packed {
        logic        ovf;
        logic [37:0] rem;
        logic [5:0]  n;
    } ln_t;

    typedef struct packed {
        logic               ovf;
        logic [5:0]         n;
        logic [31:0]        r;
        logic [32:0]        term;
        logic signed [34:0] sum;
        logic [31:0]        p;
        logic [31:0]        q;
    } tay_t;

    typedef struct packed {
        logic [31:0] num;
        logic [63:0] v;
        logic [33:0] rem;
        logic [31:0] root;
    } sq_t;

    typedef struct packed {
        logic        zero;
        logic        sat;
        logic [31:0] den;
        logic [31:0] rem;
        logic [30:0] low;
    } fd_t;

    // configuration
    logic [19:0] pop_size_reg;
    logic [15:0] hap_count_reg;
    logic [29:0] theta_reg;
    logic [29:0] cutoff_reg;
    logic        diag_reg;
    logic [21:0] dsr_reg;
    logic [21:0] dsr_next;
    logic [30:0] omt2_reg;
    logic [30:0] omt2_next;
    logic [28:0] cst_reg;
    logic [28:0] cst_next;
    logic [30:0] omt;
    logic [61:0] omt_sq;
    logic [61:0] cst_prd;

    // pipeline control
    logic            en;
    logic [NST-1:0]  vld_reg;
    item_t           it_reg [NST];
    item_t           it_next;

    // front stages
    logic [31:0] dist_reg;
    logic [31:0] dist_next;
    logic [51:0] prd_reg;
    logic [51:0] prd_next;
    div_t        div_init;
    div_t        div_reg  [DIV_ST+1];
    div_t        div_next [1:DIV_ST];
    ln_t         ln_init;
    ln_t         ln_reg  [LN_ST];
    ln_t         ln_next [LN_ST];
    tay_t        tay_init;
    tay_t        tay_reg  [TAY_ST];
    tay_t        tay_next [TAY_ST];

    // weight, numerator and shrunk variances
    logic [32:0] e_val;
    logic [6:0]  e_sh;
    logic [30:0] w_raw;
    logic [30:0] w_reg;
    logic [30:0] w_next;
    logic [62:0] a_prd;
    logic [61:0] sa_prd;
    logic [61:0] sb_prd;
    logic [31:0] a_reg;
    logic [31:0] a_next;
    logic [31:0] sa_reg;
    logic [31:0] sa_next;
    logic [31:0] sb_reg;
    logic [31:0] sb_next;
    logic [62:0] num_prd;
    logic [31:0] num_reg;
    logic [31:0] num_next;
    logic [63:0] v_reg;
    logic [63:0] v_next;

    // root and divide
    sq_t         sq_init;
    sq_t         sq_reg  [SQ_ST];
    sq_t         sq_next [SQ_ST];
    fd_t         fd_init;
    fd_t         fd_reg  [FD_ST+1];
    fd_t         fd_next [1:FD_ST];
    logic [30:0] ld_mag;
    logic [31:0] ld_reg;
    logic [31:0] ld_next;

    assign cfg_ready    = 1'b1;
    assign en           = !(vld_reg[NST-1] && result_stall);
    assign item_stall   = !en;
    assign result_valid = vld_reg[NST-1];
    assign ld_corr      = $signed(ld_reg);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_size_reg  <= POP_SIZE_RST;
            hap_count_reg <= HAP_COUNT_RST;
            theta_reg     <= '0;
            cutoff_reg    <= '0;
            diag_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_POP_SIZE:  pop_size_reg  <= cfg_data[19:0];
                REG_HAP_COUNT: hap_count_reg <= cfg_data[15:0];
                REG_THETA:     theta_reg     <= cfg_data[29:0];
                REG_CUTOFF:    cutoff_reg    <= cfg_data[29:0];
                REG_DIAG:      diag_reg      <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // derived constants
    always_comb
    begin
        dsr_next  = 22'((hap_count_reg == 16'd0) ? 16'd1 : hap_count_reg) * 22'd50;
        omt       = 31'(ONE_Q30) - 31'(theta_reg);
        omt_sq    = 62'(omt) * 62'(omt);
        omt2_next = omt_sq[60:30];
        cst_prd   = 62'(theta_reg) * 62'(32'h8000_0000 - 32'(theta_reg));
        cst_next  = cst_prd[60:32];
    end

    always_ff @(posedge clk)
    begin
        dsr_reg  <= dsr_next;
        omt2_reg <= omt2_next;
        cst_reg  <= cst_next;
    end

    // valid bits and side data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], item_valid};
    end

    always_comb
    begin
        it_next.forced     = diag_reg && (row_index >= col_index);
        it_next.forced_one = (row_index == col_index);
        it_next.neg        = cov_ab[31];
        it_next.mag        = cov_ab[31] ? (~$unsigned(cov_ab) + 32'd1) : $unsigned(cov_ab);
        it_next.va         = var_a;
        it_next.vb         = var_b;
        dist_next          = (pos_b >= pos_a) ? (pos_b - pos_a) : (pos_a - pos_b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_reg[0] <= it_next;
            for (int s = 1; s < NST; s++)
                it_reg[s] <= it_reg[s-1];
        end
    end

    // distance scaling and rate divider
    assign prd_next = 52'(pop_size_reg) * 52'(dist_reg);

    always_comb
    begin
        div_init.ovf = (prd_reg[51:21] >= 31'(dsr_reg));
        div_init.rem = prd_reg[42:21];
        div_init.low = prd_reg[20:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg   <= dist_next;
            prd_reg    <= prd_next;
            div_reg[0] <= div_init;
        end
    end

    for (genvar i = 1; i <= DIV_ST; i++)
    begin : g_div
        logic [22:0] t;
        always_comb
        begin
            div_next[i] = div_reg[i-1];
            t           = '0;
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                t = {div_next[i].rem, div_next[i].low[20]};
                div_next[i].low = {div_next[i].low[19:0], 1'b0};
                if (t >= 23'(dsr_reg))
                begin
                    div_next[i].rem    = 22'(t - 23'(dsr_reg));
                    div_next[i].low[0] = 1'b1;
                end
                else
                    div_next[i].rem = t[21:0];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                div_reg[i] <= div_next[i];
        end
    end

    // split x into n*ln2 + r
    always_comb
    begin
        ln_init.ovf = div_reg[DIV_ST].ovf;
        ln_init.rem = {1'b0, div_reg[DIV_ST].low, 16'd0};
        ln_init.n   = '0;
    end

    for (genvar i = 0; i < LN_ST; i++)
    begin : g_ln
        ln_t lin;
        if (i == 0)
        begin : g_first
            assign lin = ln_init;
        end
        else
        begin : g_rest
            assign lin = ln_reg[i-1];
        end
        always_comb
        begin
            ln_next[i] = lin;
            for (int j = 0; j < LN_STEPS; j++)
            begin
                if (ln_next[i].rem >= (LN2_Q32 << (LN_BITS - 1 - (i * LN_STEPS + j))))
                begin
                    ln_next[i].rem = ln_next[i].rem
                                   - (LN2_Q32 << (LN_BITS - 1 - (i * LN_STEPS + j)));
                    ln_next[i].n[LN_BITS - 1 - (i * LN_STEPS + j)] = 1'b1;
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                ln_reg[i] <= ln_next[i];
        end
    end

    // exp(-r) taylor series, three stages per term
    always_comb
    begin
        tay_init.ovf  = ln_reg[LN_ST-1].ovf;
        tay_init.n    = ln_reg[LN_ST-1].n;
        tay_init.r    = ln_reg[LN_ST-1].rem[31:0];
        tay_init.term = 33'h1_0000_0000;
        tay_init.sum  = 35'sh1_0000_0000;
        tay_init.p    = '0;
        tay_init.q    = '0;
    end

    for (genvar s = 0; s < TAY_ST; s++)
    begin : g_tay
        localparam int K   = s / 3 + 1;
        localparam int SUB = s % 3;
        localparam logic [36:0] RCP = recip(K);
        tay_t tin;
        if (s == 0)
        begin : g_first
            assign tin = tay_init;
        end
        else
        begin : g_rest
            assign tin = tay_reg[s-1];
        end
        if (SUB == 0)
        begin : g_mul
            logic [64:0] prd;
            always_comb
            begin
                prd         = 65'(tin.term) * 65'(tin.r);
                tay_next[s] = tin;
                tay_next[s].p = prd[63:32];
            end
        end
        else if (SUB == 1)
        begin : g_rcp
            logic [68:0] prd;
            always_comb
            begin
                prd         = 69'(tin.p) * 69'(RCP);
                tay_next[s] = tin;
                tay_next[s].q = prd[67:36];
            end
        end
        else
        begin : g_acc
            logic [35:0] chk;
            logic [31:0] qf;
            always_comb
            begin
                chk         = 36'(tin.p) - 36'(tin.q) * 36'(K);
                qf          = (chk >= 36'(K)) ? (tin.q + 32'd1) : tin.q;
                tay_next[s] = tin;
                tay_next[s].term = {1'b0, qf};
                if (K % 2 == 1)
                    tay_next[s].sum = tin.sum - $signed(35'(qf));
                else
                    tay_next[s].sum = tin.sum + $signed(35'(qf));
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                tay_reg[s] <= tay_next[s];
        end
    end

    // weight, numerator, shrunk variances
    always_comb
    begin
        e_val  = tay_reg[TAY_ST-1].sum[34] ? 33'd0 : tay_reg[TAY_ST-1].sum[32:0];
        e_sh   = 7'(tay_reg[TAY_ST-1].n) + 7'd2;
        w_raw  = 31'(e_val >> e_sh);
        if (tay_reg[TAY_ST-1].ovf || (w_raw < 31'(cutoff_reg)))
            w_next = '0;
        else
            w_next = w_raw;
    end

    always_comb
    begin
        a_prd    = 63'(it_reg[3 + DIV_ST + LN_ST + TAY_ST].mag) * 63'(w_reg);
        a_next   = a_prd[61:30];
        sa_prd   = 62'(it_reg[3 + DIV_ST + LN_ST + TAY_ST].va) * 62'(omt2_reg);
        sb_prd   = 62'(it_reg[3 + DIV_ST + LN_ST + TAY_ST].vb) * 62'(omt2_reg);
        sa_next  = sa_prd[61:30] + 32'(cst_reg);
        sb_next  = sb_prd[61:30] + 32'(cst_reg);
        num_prd  = 63'(a_reg) * 63'(omt2_reg);
        num_next = num_prd[61:30];
        v_next   = 64'(sa_reg) * 64'(sb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg   <= w_next;
            a_reg   <= a_next;
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
            num_reg <= num_next;
            v_reg   <= v_next;
        end
    end

    // integer square root, two bits per stage
    always_comb
    begin
        sq_init.num  = num_reg;
        sq_init.v    = v_reg;
        sq_init.rem  = '0;
        sq_init.root = '0;
    end

    for (genvar i = 0; i < SQ_ST; i++)
    begin : g_sq
        sq_t         sin;
        logic [35:0] r2;
        logic [35:0] trial;
        if (i == 0)
        begin : g_first
            assign sin = sq_init;
        end
        else
        begin : g_rest
            assign sin = sq_reg[i-1];
        end
        always_comb
        begin
            sq_next[i] = sin;
            r2         = '0;
            trial      = '0;
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                if (i * SQ_STEPS + j < SQ_BITS)
                begin
                    r2    = {sq_next[i].rem, sq_next[i].v[63:62]};
                    trial = {2'b00, sq_next[i].root, 2'b01};
                    sq_next[i].v = {sq_next[i].v[61:0], 2'b00};
                    if (r2 >= trial)
                    begin
                        sq_next[i].rem  = 34'(r2 - trial);
                        sq_next[i].root = {sq_next[i].root[30:0], 1'b1};
                    end
                    else
                    begin
                        sq_next[i].rem  = r2[33:0];
                        sq_next[i].root = {sq_next[i].root[30:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                sq_reg[i] <= sq_next[i];
        end
    end

    // saturating divide num * 2^30 / den
    always_comb
    begin
        fd_init.zero = (sq_reg[SQ_ST-1].num == 32'd0);
        fd_init.sat  = (32'(sq_reg[SQ_ST-1].num[31:1]) >= sq_reg[SQ_ST-1].root);
        fd_init.den  = sq_reg[SQ_ST-1].root;
        fd_init.rem  = 32'(sq_reg[SQ_ST-1].num[31:1]);
        fd_init.low  = {sq_reg[SQ_ST-1].num[0], 30'd0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fd_reg[0] <= fd_init;
    end

    for (genvar i = 1; i <= FD_ST; i++)
    begin : g_fd
        logic [32:0] t;
        always_comb
        begin
            fd_next[i] = fd_reg[i-1];
            t          = '0;
            for (int j = 0; j < FD_STEPS; j++)
            begin
                if ((i - 1) * FD_STEPS + j < FD_BITS)
                begin
                    t = {fd_next[i].rem, fd_next[i].low[30]};
                    fd_next[i].low = {fd_next[i].low[29:0], 1'b0};
                    if (t >= 33'(fd_next[i].den))
                    begin
                        fd_next[i].rem    = 32'(t - 33'(fd_next[i].den));
                        fd_next[i].low[0] = 1'b1;
                    end
                    else
                        fd_next[i].rem = t[31:0];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                fd_reg[i] <= fd_next[i];
        end
    end

    // sign, diagonal override and output register
    always_comb
    begin
        if (fd_reg[FD_ST].zero)
            ld_mag = '0;
        else if (fd_reg[FD_ST].sat || (fd_reg[FD_ST].low > ONE_Q30))
            ld_mag = ONE_Q30;
        else
            ld_mag = fd_reg[FD_ST].low;

        if (it_reg[NST-2].forced)
            ld_next = it_reg[NST-2].forced_one ? 32'(ONE_Q30) : 32'd0;
        else if (it_reg[NST-2].neg)
            ld_next = 32'd0 - 32'(ld_mag);
        else
            ld_next = 32'(ld_mag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ld_reg <= ld_next;
    end

endmodule
`default_nettype wire
